// ----- hdl/gplr_pkg.sv -----
// Shared types and constant codes for the game-pad link responder.
package gplr_pkg;

    typedef logic [7:0] t_byte;

    // One host exchange together with a snapshot of the pad inputs.
    typedef struct packed {
        logic  kind;
        t_byte host_byte;
        t_byte pad_low;
        t_byte pad_high;
        t_byte right_x;
        t_byte right_y;
        t_byte left_x;
        t_byte left_y;
        t_byte left_trigger;
        t_byte right_trigger;
    } t_in_beat;

    // The byte the device drives during the next exchange.
    typedef struct packed {
        logic  reply_valid;
        t_byte reply_byte;
        logic  reply_last;
    } t_out_beat;

    typedef logic [3:0]        t_cmd;
    typedef logic [1:0]        t_mode;
    typedef logic [4:0]        t_phase;
    typedef logic [5:0][7:0]   t_motor_map;
    typedef logic [3:0][7:0]   t_pres_en;
    typedef logic [7:0][7:0]   t_pad_latch;

    // Internal command codes.
    localparam t_cmd CMD_NONE            = 4'd0;
    localparam t_cmd CMD_PRES_CFG        = 4'd1;
    localparam t_cmd CMD_ANALOG_QUERY    = 4'd2;
    localparam t_cmd CMD_PAD_READ        = 4'd3;
    localparam t_cmd CMD_CFG_IN_CFG      = 4'd4;
    localparam t_cmd CMD_ANALOG_SW       = 4'd5;
    localparam t_cmd CMD_DEV_INFO        = 4'd6;
    localparam t_cmd CMD_CONST46         = 4'd7;
    localparam t_cmd CMD_CONST47         = 4'd8;
    localparam t_cmd CMD_CONST4C         = 4'd9;
    localparam t_cmd CMD_MOTOR           = 4'd10;
    localparam t_cmd CMD_PRES_EN         = 4'd11;
    localparam t_cmd CMD_CFG_FROM_PAD    = 4'd12;

    // Pad modes.
    localparam t_mode MODE_BUTTONS  = 2'd0;
    localparam t_mode MODE_STICKS   = 2'd1;
    localparam t_mode MODE_PRESSURE = 2'd2;

    // Transaction phases; reply byte k is on the wire in phase k + 2.
    localparam t_phase PHASE_IDLE   = 5'd0;
    localparam t_phase PHASE_CMD    = 5'd1;
    localparam t_phase PHASE_REPLY0 = 5'd2;

    // Reply lengths.
    localparam t_phase LEN_DIGITAL  = 5'd3;
    localparam t_phase LEN_ANALOG   = 5'd7;
    localparam t_phase LEN_PRESSURE = 5'd19;
    localparam t_phase LEN_CONFIG   = 5'd7;

    // Slots of the latched pad snapshot.
    localparam logic [2:0] PAD_LOW           = 3'd0;
    localparam logic [2:0] PAD_HIGH          = 3'd1;
    localparam logic [2:0] PAD_RIGHT_X       = 3'd2;
    localparam logic [2:0] PAD_RIGHT_Y       = 3'd3;
    localparam logic [2:0] PAD_LEFT_X        = 3'd4;
    localparam logic [2:0] PAD_LEFT_Y        = 3'd5;
    localparam logic [2:0] PAD_LEFT_TRIGGER  = 3'd6;
    localparam logic [2:0] PAD_RIGHT_TRIGGER = 3'd7;

    localparam t_byte BYTE_IDLE   = 8'hFF;
    localparam t_byte BYTE_HEADER = 8'h5A;

    // Bytes the host sends on the link.
    localparam t_byte HOST_ADDR            = 8'h01;
    localparam t_byte HOST_PRES_CFG        = 8'h40;
    localparam t_byte HOST_POLL_CFG_STATUS = 8'h41;
    localparam t_byte HOST_POLL            = 8'h42;
    localparam t_byte HOST_CONFIG          = 8'h43;
    localparam t_byte HOST_ANALOG_SW       = 8'h44;
    localparam t_byte HOST_STATUS          = 8'h45;
    localparam t_byte HOST_CONST46         = 8'h46;
    localparam t_byte HOST_CONST47         = 8'h47;
    localparam t_byte HOST_CONST4C         = 8'h4C;
    localparam t_byte HOST_MOTOR           = 8'h4D;
    localparam t_byte HOST_PRES_EN         = 8'h4F;

    // Argument of the analog switch that selects an analog mode.
    localparam t_byte ANALOG_ON = 8'h01;

    // Mode IDs sent back in answer to the address byte.
    localparam t_byte ID_DIGITAL  = 8'h41;
    localparam t_byte ID_ANALOG   = 8'h73;
    localparam t_byte ID_PRESSURE = 8'h79;
    localparam t_byte ID_CONFIG   = 8'hF3;

endpackage

// ----- hdl/gplr_in_if.sv -----
// Valid/ready channel carrying host exchange beats.
interface gplr_in_if;
    logic                valid;
    logic                ready;
    gplr_pkg::t_in_beat  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/gplr_out_if.sv -----
// Valid/ready channel carrying reply beats.
interface gplr_out_if;
    logic                valid;
    logic                ready;
    gplr_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/gplr_in_stage.sv -----
// Input register stage that holds one accepted host beat.
module gplr_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gplr_pkg::t_in_beat i_in_beat,
    output logic               o_valid,
    input  logic               i_take,
    output gplr_pkg::t_in_beat o_beat
);

    logic               r_valid;
    gplr_pkg::t_in_beat r_beat;

    assign o_in_ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_beat     = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_beat <= i_in_beat;
        end
    end

endmodule

// ----- hdl/gplr_reply.sv -----
// Reply byte selection for a given command, reply index and device state.
module gplr_reply (
    input  gplr_pkg::t_cmd       i_cmd,
    input  gplr_pkg::t_mode      i_mode,
    input  logic                 i_offset_nz,
    input  gplr_pkg::t_motor_map i_motor,
    input  gplr_pkg::t_pad_latch i_pad,
    input  gplr_pkg::t_phase     i_index,
    output gplr_pkg::t_byte      o_byte
);

    // Fixed seven-byte replies, entry 0 at the right; the eighth entry is padding.
    localparam logic [7:0][7:0] T40 =
        {8'h00, 8'h5A, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h5A};
    localparam logic [7:0][7:0] T41 =
        {8'h00, 8'h5A, 8'h00, 8'h00, 8'h03, 8'hFF, 8'hFF, 8'h5A};
    localparam logic [7:0][7:0] T45 =
        {8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h02, 8'h03, 8'h5A};
    localparam logic [7:0][7:0] T47 =
        {8'h00, 8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h5A};

    // Pressure bytes four to nine come from the second button byte.
    localparam logic [15:0] PRES_FROM_HIGH = 16'b0000_0011_1111_0000;

    function automatic logic [2:0] pres_bit_of(input logic [3:0] idx);
        logic [2:0] b;
        case (idx)
            4'd0:    b = 3'd5;
            4'd1:    b = 3'd7;
            4'd2:    b = 3'd4;
            4'd3:    b = 3'd6;
            4'd4:    b = 3'd4;
            4'd5:    b = 3'd5;
            4'd6:    b = 3'd6;
            4'd7:    b = 3'd7;
            4'd8:    b = 3'd2;
            4'd9:    b = 3'd3;
            default: b = 3'd0;
        endcase
        return b;
    endfunction

    logic            dig;
    logic            lt7;
    logic [2:0]      tbl_i;
    logic [3:0]      pres_i;
    gplr_pkg::t_byte pres_src;
    gplr_pkg::t_byte frame;

    always_comb begin
        dig      = !(i_mode == gplr_pkg::MODE_STICKS || i_mode == gplr_pkg::MODE_PRESSURE);
        lt7      = i_index < 5'd7;
        tbl_i    = i_index[2:0];
        pres_i   = 4'(i_index - 5'd7);
        pres_src = PRES_FROM_HIGH[pres_i] ? i_pad[gplr_pkg::PAD_HIGH]
                                          : i_pad[gplr_pkg::PAD_LOW];

        // Pad frame: buttons and sticks, then pressures, then triggers.
        if (i_index <= 5'd6) begin
            frame = i_pad[3'(i_index - 5'd1)];
        end else if (i_index <= 5'd16) begin
            frame = pres_src[pres_bit_of(pres_i)] ? 8'h00 : 8'hFF;
        end else if (i_index == 5'd17) begin
            frame = i_pad[gplr_pkg::PAD_LEFT_TRIGGER];
        end else if (i_index == 5'd18) begin
            frame = i_pad[gplr_pkg::PAD_RIGHT_TRIGGER];
        end else begin
            frame = 8'h00;
        end

        o_byte = 8'h00;
        if (i_index >= gplr_pkg::LEN_PRESSURE) begin
            o_byte = 8'h00;
        end else if (i_index == 5'd0) begin
            o_byte = gplr_pkg::BYTE_HEADER;
        end else begin
            case (i_cmd)
                gplr_pkg::CMD_PAD_READ, gplr_pkg::CMD_CFG_FROM_PAD: begin
                    o_byte = frame;
                end
                gplr_pkg::CMD_PRES_CFG: begin
                    o_byte = lt7 ? T40[tbl_i] : 8'h00;
                end
                gplr_pkg::CMD_ANALOG_QUERY: begin
                    o_byte = (dig || !lt7) ? 8'h00 : T41[tbl_i];
                end
                gplr_pkg::CMD_DEV_INFO: begin
                    if (i_index == 5'd3) begin
                        o_byte = dig ? 8'h00 : 8'h01;
                    end else begin
                        o_byte = lt7 ? T45[tbl_i] : 8'h00;
                    end
                end
                gplr_pkg::CMD_CONST46: begin
                    if (i_index == 5'd3) begin
                        o_byte = 8'h01;
                    end else if (i_index == 5'd4) begin
                        o_byte = i_offset_nz ? 8'h01 : 8'h02;
                    end else if (i_index == 5'd5) begin
                        o_byte = i_offset_nz ? 8'h01 : 8'h00;
                    end else if (i_index == 5'd6) begin
                        o_byte = 8'h0F;
                    end
                end
                gplr_pkg::CMD_CONST47: begin
                    o_byte = lt7 ? T47[tbl_i] : 8'h00;
                end
                gplr_pkg::CMD_CONST4C: begin
                    if (i_index == 5'd4) begin
                        o_byte = i_offset_nz ? 8'h07 : 8'h04;
                    end
                end
                gplr_pkg::CMD_MOTOR: begin
                    if (i_index <= 5'd6) begin
                        o_byte = i_motor[3'(i_index - 5'd1)];
                    end
                end
                gplr_pkg::CMD_PRES_EN: begin
                    if (i_index == 5'd6) begin
                        o_byte = gplr_pkg::BYTE_HEADER;
                    end
                end
                default: begin
                    o_byte = 8'h00;
                end
            endcase
        end
    end

endmodule

// ----- hdl/gplr_engine.sv -----
// Transaction state, command handling and the result register.
module gplr_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_take,
    input  gplr_pkg::t_in_beat  i_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output gplr_pkg::t_out_beat o_out
);

    gplr_pkg::t_phase     r_phase,  n_phase;
    gplr_pkg::t_cmd       r_cmd,    n_cmd;
    gplr_pkg::t_mode      r_mode,   n_mode;
    logic                 r_cfg,    n_cfg;
    logic                 r_off_nz, n_off_nz;
    gplr_pkg::t_motor_map r_motor,  n_motor;
    gplr_pkg::t_pres_en   r_pres,   n_pres;
    gplr_pkg::t_pad_latch r_pad,    n_pad;
    logic                 r_out_valid;
    gplr_pkg::t_out_beat  r_out,    n_out;

    logic                 take;
    logic                 any_pres;
    gplr_pkg::t_phase     k;
    gplr_pkg::t_phase     j;
    gplr_pkg::t_phase     len;
    gplr_pkg::t_byte      reply;

    function automatic gplr_pkg::t_cmd decode(input gplr_pkg::t_byte h, input logic cfg);
        gplr_pkg::t_cmd c;
        case (h)
            gplr_pkg::HOST_PRES_CFG:        c = gplr_pkg::CMD_PRES_CFG;
            gplr_pkg::HOST_POLL_CFG_STATUS: c = gplr_pkg::CMD_ANALOG_QUERY;
            gplr_pkg::HOST_ANALOG_SW:       c = gplr_pkg::CMD_ANALOG_SW;
            gplr_pkg::HOST_STATUS:          c = gplr_pkg::CMD_DEV_INFO;
            gplr_pkg::HOST_CONST46:         c = gplr_pkg::CMD_CONST46;
            gplr_pkg::HOST_CONST47:         c = gplr_pkg::CMD_CONST47;
            gplr_pkg::HOST_CONST4C:         c = gplr_pkg::CMD_CONST4C;
            gplr_pkg::HOST_MOTOR:           c = gplr_pkg::CMD_MOTOR;
            gplr_pkg::HOST_PRES_EN:         c = gplr_pkg::CMD_PRES_EN;
            default:                        c = gplr_pkg::CMD_NONE;
        endcase
        if (!cfg) begin
            c = gplr_pkg::CMD_NONE;
        end
        if (h == gplr_pkg::HOST_POLL) begin
            c = gplr_pkg::CMD_PAD_READ;
        end else if (h == gplr_pkg::HOST_CONFIG) begin
            c = cfg ? gplr_pkg::CMD_CFG_IN_CFG : gplr_pkg::CMD_CFG_FROM_PAD;
        end
        return c;
    endfunction

    function automatic gplr_pkg::t_byte mode_id(input logic cfg, input gplr_pkg::t_mode m);
        gplr_pkg::t_byte id;
        if (cfg) begin
            id = gplr_pkg::ID_CONFIG;
        end else if (m == gplr_pkg::MODE_STICKS) begin
            id = gplr_pkg::ID_ANALOG;
        end else if (m == gplr_pkg::MODE_PRESSURE) begin
            id = gplr_pkg::ID_PRESSURE;
        end else begin
            id = gplr_pkg::ID_DIGITAL;
        end
        return id;
    endfunction

    assign take        = i_valid && (!r_out_valid || i_out_ready);
    assign o_take      = take;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign any_pres    = |r_pres;
    assign k           = r_phase - gplr_pkg::PHASE_REPLY0;
    assign j           = r_phase - gplr_pkg::PHASE_CMD;

    // The next reply byte sees updates made by this host byte.
    gplr_reply u_reply (
        .i_cmd       (r_cmd),
        .i_mode      (n_mode),
        .i_offset_nz (n_off_nz),
        .i_motor     (n_motor),
        .i_pad       (r_pad),
        .i_index     (j),
        .o_byte      (reply)
    );

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_mode   = r_mode;
        n_cfg    = r_cfg;
        n_off_nz = r_off_nz;
        n_motor  = r_motor;
        n_pres   = r_pres;
        n_pad    = r_pad;
        n_out.reply_valid = 1'b0;
        n_out.reply_byte  = gplr_pkg::BYTE_IDLE;
        n_out.reply_last  = 1'b0;

        // Pad frames never change the mode while they run.
        if ((r_cmd == gplr_pkg::CMD_PAD_READ) || (r_cmd == gplr_pkg::CMD_CFG_FROM_PAD)) begin
            if (r_mode == gplr_pkg::MODE_STICKS) begin
                len = gplr_pkg::LEN_ANALOG;
            end else if (r_mode == gplr_pkg::MODE_PRESSURE) begin
                len = gplr_pkg::LEN_PRESSURE;
            end else begin
                len = gplr_pkg::LEN_DIGITAL;
            end
        end else begin
            len = gplr_pkg::LEN_CONFIG;
        end

        if (i_beat.kind) begin
            n_phase = gplr_pkg::PHASE_IDLE;
            n_cmd   = gplr_pkg::CMD_NONE;
        end else if (r_phase == gplr_pkg::PHASE_IDLE) begin
            if (i_beat.host_byte == gplr_pkg::HOST_ADDR) begin
                n_out.reply_valid = 1'b1;
                n_out.reply_byte  = mode_id(r_cfg, r_mode);
                n_phase           = gplr_pkg::PHASE_CMD;
            end
        end else if (r_phase == gplr_pkg::PHASE_CMD) begin
            n_cmd = decode(i_beat.host_byte, r_cfg);
            if (n_cmd == gplr_pkg::CMD_NONE) begin
                n_phase = gplr_pkg::PHASE_IDLE;
            end else begin
                n_pad[gplr_pkg::PAD_LOW]           = i_beat.pad_low;
                n_pad[gplr_pkg::PAD_HIGH]          = i_beat.pad_high;
                n_pad[gplr_pkg::PAD_RIGHT_X]       = i_beat.right_x;
                n_pad[gplr_pkg::PAD_RIGHT_Y]       = i_beat.right_y;
                n_pad[gplr_pkg::PAD_LEFT_X]        = i_beat.left_x;
                n_pad[gplr_pkg::PAD_LEFT_Y]        = i_beat.left_y;
                n_pad[gplr_pkg::PAD_LEFT_TRIGGER]  = i_beat.left_trigger;
                n_pad[gplr_pkg::PAD_RIGHT_TRIGGER] = i_beat.right_trigger;
                if (n_cmd == gplr_pkg::CMD_PAD_READ) begin
                    n_cfg = 1'b0;
                end
                n_out.reply_valid = 1'b1;
                n_out.reply_byte  = gplr_pkg::BYTE_HEADER;
                n_phase           = gplr_pkg::PHASE_REPLY0;
            end
        end else begin
            // Host byte that arrived with reply byte k.
            case (r_cmd)
                gplr_pkg::CMD_CFG_IN_CFG, gplr_pkg::CMD_CFG_FROM_PAD: begin
                    if (k == 5'd1) begin
                        n_cfg = (i_beat.host_byte != 8'h00);
                    end
                end
                gplr_pkg::CMD_ANALOG_SW: begin
                    if (k == 5'd1) begin
                        if (i_beat.host_byte == gplr_pkg::ANALOG_ON) begin
                            n_mode = any_pres ? gplr_pkg::MODE_PRESSURE
                                              : gplr_pkg::MODE_STICKS;
                        end else begin
                            n_mode = gplr_pkg::MODE_BUTTONS;
                        end
                    end
                end
                gplr_pkg::CMD_CONST46, gplr_pkg::CMD_CONST4C: begin
                    if (k == 5'd1) begin
                        n_off_nz = (i_beat.host_byte != 8'h00);
                    end
                end
                gplr_pkg::CMD_MOTOR: begin
                    if (k >= 5'd1 && k <= 5'd6) begin
                        n_motor[3'(k - 5'd1)] = i_beat.host_byte;
                    end
                end
                gplr_pkg::CMD_PRES_EN: begin
                    if (k >= 5'd1 && k <= 5'd4) begin
                        n_pres[2'(k - 5'd1)] = i_beat.host_byte;
                    end
                    if (k == 5'd6) begin
                        n_mode = any_pres ? gplr_pkg::MODE_PRESSURE : gplr_pkg::MODE_STICKS;
                    end
                end
                default: begin
                end
            endcase

            if (j < len) begin
                n_out.reply_valid = 1'b1;
                n_out.reply_byte  = reply;
                n_out.reply_last  = (5'(j + 5'd1) == len);
                n_phase           = r_phase + 5'd1;
            end else begin
                n_phase = gplr_pkg::PHASE_IDLE;
                n_cmd   = gplr_pkg::CMD_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= gplr_pkg::PHASE_IDLE;
            r_cmd       <= gplr_pkg::CMD_NONE;
            r_mode      <= gplr_pkg::MODE_BUTTONS;
            r_cfg       <= 1'b0;
            r_off_nz    <= 1'b0;
            r_motor     <= {6{8'hFF}};
            r_pres      <= '0;
            r_pad       <= {8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF};
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase  <= n_phase;
                r_cmd    <= n_cmd;
                r_mode   <= n_mode;
                r_cfg    <= n_cfg;
                r_off_nz <= n_off_nz;
                r_motor  <= n_motor;
                r_pres   <= n_pres;
                r_pad    <= n_pad;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    // An idle reply always carries the idle byte and no last flag.
    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.reply_valid) |->
            (r_out.reply_byte == gplr_pkg::BYTE_IDLE && !r_out.reply_last))
        else $error("idle reply with non-idle payload");

    // A reply never runs past the longest pad frame.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= 5'd20)
        else $error("phase out of range");

    // An abort always returns the transaction to idle.
    a_abort_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_beat.kind) |=>
            (r_phase == gplr_pkg::PHASE_IDLE && r_cmd == gplr_pkg::CMD_NONE))
        else $error("abort did not clear the transaction");

    // The unused mode code is never entered.
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != 2'd3)
        else $error("unused pad mode reached");

    // A reply in progress always has a command behind it.
    a_reply_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase >= gplr_pkg::PHASE_REPLY0) |-> (r_cmd != gplr_pkg::CMD_NONE))
        else $error("reply phase without command");

endmodule

// ----- hdl/game_pad_link_responder_unit.sv -----
// Top level of the game-pad link responder: input register, engine and result register.
//
//   Channel | Direction | Beat contents
//   --------+-----------+-----------------------------------------------------
//   i_in    | in        | kind, host_byte, pad_low/high, sticks, triggers
//   o_out   | out       | reply_valid, reply_byte, reply_last
//
// Every input beat produces exactly one output beat. An accepted beat sits in the
// input register while the engine decodes it, and the result register captures its
// reply when the engine takes the beat; one beat per cycle is sustained while o_out
// does not stall. The result register advances whenever it is empty or its beat is
// taken; during a stall on o_out the input register takes one more beat and then
// i_in.ready drops. Reset is synchronous and active low; it returns the link to
// idle, digital mode, config off and the motor map to 0xFF.
module game_pad_link_responder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gplr_in_if.sink     i_in,
    gplr_out_if.source  o_out
);

    // Registered host beat handed from the input stage to the engine.
    logic               s1_valid;
    logic               s1_take;
    gplr_pkg::t_in_beat s1_beat;

    gplr_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_in_beat  (i_in.data),
        .o_valid    (s1_valid),
        .i_take     (s1_take),
        .o_beat     (s1_beat)
    );

    // The engine owns all transaction state and the result register; its transaction
    // state changes only on the cycle it takes a beat from the input stage.
    gplr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .o_take      (s1_take),
        .i_beat      (s1_beat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out       (o_out.data)
    );

endmodule

// ----- tb/sv/gplr_tb_pkg.sv -----
// Reply length bound and the reply tracker used by the game-pad link responder testbench.
package gplr_tb_pkg;

    import gplr_pkg::*;

    localparam int unsigned MAX_REPLY = 19;

    // Tracks the link state, works out the reply to every accepted exchange
    // and compares the replies that come out of the block.
    class reply_tracker;
        t_phase      phase;
        t_cmd        cmd;
        t_mode       mode;
        logic        cfg_on;
        logic        ofs_nz;
        t_motor_map  motor;
        t_pres_en    pres;
        t_pad_latch  pad;
        t_out_beat   replies_due[$];
        int unsigned bad_replies;

        function new();
            phase  = PHASE_IDLE;
            cmd    = CMD_NONE;
            mode   = MODE_BUTTONS;
            cfg_on = 1'b0;
            ofs_nz = 1'b0;
            motor  = {6{8'hFF}};
            pres   = '0;
            pad    = '0;
            pad[PAD_LOW]     = 8'hFF;
            pad[PAD_HIGH]    = 8'hFF;
            pad[PAD_RIGHT_X] = 8'h80;
            pad[PAD_RIGHT_Y] = 8'h80;
            pad[PAD_LEFT_X]  = 8'h80;
            pad[PAD_LEFT_Y]  = 8'h80;
            bad_replies = 0;
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction

        function t_byte mode_id();
            if (cfg_on) return ID_CONFIG;
            case (mode)
                MODE_STICKS:   return ID_ANALOG;
                MODE_PRESSURE: return ID_PRESSURE;
                default:       return ID_DIGITAL;
            endcase
        endfunction

        function int unsigned reply_len();
            if (cmd != CMD_PAD_READ && cmd != CMD_CFG_FROM_PAD) return LEN_CONFIG;
            case (mode)
                MODE_STICKS:   return LEN_ANALOG;
                MODE_PRESSURE: return LEN_PRESSURE;
                default:       return LEN_DIGITAL;
            endcase
        endfunction

        // Raw (active low) button bit behind pressure byte i of a pad frame.
        function logic button_bit(int unsigned i);
            case (i)
                0:       return pad[PAD_LOW][5];
                1:       return pad[PAD_LOW][7];
                2:       return pad[PAD_LOW][4];
                3:       return pad[PAD_LOW][6];
                4:       return pad[PAD_HIGH][4];
                5:       return pad[PAD_HIGH][5];
                6:       return pad[PAD_HIGH][6];
                7:       return pad[PAD_HIGH][7];
                8:       return pad[PAD_HIGH][2];
                default: return pad[PAD_HIGH][3];
            endcase
        endfunction

        function t_byte frame_byte(int unsigned k);
            if (k == 0) return BYTE_HEADER;
            if (k <= 6) return pad[k - 1];
            if (k <= 16) return button_bit(k - 7) ? 8'h00 : 8'hFF;
            if (k == 17) return pad[PAD_LEFT_TRIGGER];
            if (k == 18) return pad[PAD_RIGHT_TRIGGER];
            return 8'h00;
        endfunction

        function t_byte reply_byte_at(int unsigned k);
            logic dig;
            dig = (mode != MODE_STICKS && mode != MODE_PRESSURE);
            if (k >= MAX_REPLY) return 8'h00;
            if (k == 0) return BYTE_HEADER;
            case (cmd)
                CMD_PAD_READ, CMD_CFG_FROM_PAD: return frame_byte(k);
                CMD_PRES_CFG: begin
                    case (k)
                        3:       return 8'h02;
                        6:       return 8'h5A;
                        default: return 8'h00;
                    endcase
                end
                CMD_ANALOG_QUERY: begin
                    if (dig) return 8'h00;
                    case (k)
                        1, 2:    return 8'hFF;
                        3:       return 8'h03;
                        6:       return 8'h5A;
                        default: return 8'h00;
                    endcase
                end
                CMD_DEV_INFO: begin
                    case (k)
                        1:       return 8'h03;
                        2:       return 8'h02;
                        3:       return dig ? 8'h00 : 8'h01;
                        4:       return 8'h02;
                        5:       return 8'h01;
                        default: return 8'h00;
                    endcase
                end
                CMD_CONST46: begin
                    case (k)
                        3:       return 8'h01;
                        4:       return ofs_nz ? 8'h01 : 8'h02;
                        5:       return ofs_nz ? 8'h01 : 8'h00;
                        6:       return 8'h0F;
                        default: return 8'h00;
                    endcase
                end
                CMD_CONST47: begin
                    case (k)
                        3:       return 8'h02;
                        5:       return 8'h01;
                        default: return 8'h00;
                    endcase
                end
                CMD_CONST4C: return (k == 4) ? (ofs_nz ? 8'h07 : 8'h04) : 8'h00;
                CMD_MOTOR:   return (k <= 6) ? motor[k - 1] : 8'h00;
                CMD_PRES_EN: return (k == 6) ? 8'h5A : 8'h00;
                default:     return 8'h00;
            endcase
        endfunction

        // Host byte that arrives while reply byte k is on the wire.
        function void take_host(int unsigned k, t_byte h);
            case (cmd)
                CMD_CFG_IN_CFG, CMD_CFG_FROM_PAD: begin
                    if (k == 1) cfg_on = (h != 8'h00);
                end
                CMD_ANALOG_SW: begin
                    if (k == 1) begin
                        if (h == ANALOG_ON) mode = (|pres) ? MODE_PRESSURE : MODE_STICKS;
                        else mode = MODE_BUTTONS;
                    end
                end
                CMD_CONST46, CMD_CONST4C: begin
                    if (k == 1) ofs_nz = (h != 8'h00);
                end
                CMD_MOTOR: begin
                    if (k >= 1 && k <= 6) motor[k - 1] = h;
                end
                CMD_PRES_EN: begin
                    if (k >= 1 && k <= 4) pres[k - 1] = h;
                    if (k == 6) mode = (|pres) ? MODE_PRESSURE : MODE_STICKS;
                end
                default: ;
            endcase
        endfunction

        function t_cmd decode(t_byte h);
            t_cmd c;
            case (h)
                HOST_POLL:            return CMD_PAD_READ;
                HOST_CONFIG:          return cfg_on ? CMD_CFG_IN_CFG : CMD_CFG_FROM_PAD;
                HOST_PRES_CFG:        c = CMD_PRES_CFG;
                HOST_POLL_CFG_STATUS: c = CMD_ANALOG_QUERY;
                HOST_ANALOG_SW:       c = CMD_ANALOG_SW;
                HOST_STATUS:          c = CMD_DEV_INFO;
                HOST_CONST46:         c = CMD_CONST46;
                HOST_CONST47:         c = CMD_CONST47;
                HOST_CONST4C:         c = CMD_CONST4C;
                HOST_MOTOR:           c = CMD_MOTOR;
                HOST_PRES_EN:         c = CMD_PRES_EN;
                default:              return CMD_NONE;
            endcase
            return cfg_on ? c : CMD_NONE;
        endfunction

        // Advances the link state by one accepted exchange and queues its reply.
        function void note_exchange(t_in_beat b);
            t_out_beat   r;
            int unsigned k;
            r.reply_valid = 1'b0;
            r.reply_byte  = BYTE_IDLE;
            r.reply_last  = 1'b0;
            if (b.kind) begin
                phase = PHASE_IDLE;
                cmd   = CMD_NONE;
            end else if (phase == PHASE_IDLE) begin
                if (b.host_byte == HOST_ADDR) begin
                    r.reply_valid = 1'b1;
                    r.reply_byte  = mode_id();
                    phase = PHASE_CMD;
                end
            end else if (phase == PHASE_CMD) begin
                cmd = decode(b.host_byte);
                if (cmd == CMD_NONE) begin
                    phase = PHASE_IDLE;
                end else begin
                    pad[PAD_LOW]           = b.pad_low;
                    pad[PAD_HIGH]          = b.pad_high;
                    pad[PAD_RIGHT_X]       = b.right_x;
                    pad[PAD_RIGHT_Y]       = b.right_y;
                    pad[PAD_LEFT_X]        = b.left_x;
                    pad[PAD_LEFT_Y]        = b.left_y;
                    pad[PAD_LEFT_TRIGGER]  = b.left_trigger;
                    pad[PAD_RIGHT_TRIGGER] = b.right_trigger;
                    if (cmd == CMD_PAD_READ) cfg_on = 1'b0;
                    r.reply_valid = 1'b1;
                    r.reply_byte  = reply_byte_at(0);
                    r.reply_last  = (reply_len() == 1);
                    phase = PHASE_REPLY0;
                end
            end else begin
                k = phase - PHASE_REPLY0;
                take_host(k, b.host_byte);
                if (k + 1 < reply_len() && k + 1 < MAX_REPLY) begin
                    r.reply_valid = 1'b1;
                    r.reply_byte  = reply_byte_at(k + 1);
                    r.reply_last  = (k + 2 == reply_len());
                    phase = t_phase'(k + 3);
                end else begin
                    phase = PHASE_IDLE;
                    cmd   = CMD_NONE;
                end
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(t_out_beat got);
            t_out_beat want;
            if (replies_due.size() == 0) begin
                bad_replies++;
                if (bad_replies <= 10)
                    $display("unexpected reply: valid=%0b byte=%02h last=%0b",
                             got.reply_valid, got.reply_byte, got.reply_last);
                return;
            end
            want = replies_due.pop_front();
            if (got.reply_valid !== want.reply_valid || got.reply_byte !== want.reply_byte ||
                got.reply_last !== want.reply_last) begin
                bad_replies++;
                if (bad_replies <= 10)
                    $display("reply mismatch: expected %0b/%02h/%0b, got %0b/%02h/%0b",
                             want.reply_valid, want.reply_byte, want.reply_last,
                             got.reply_valid, got.reply_byte, got.reply_last);
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_game_pad_link_responder_unit.sv -----
// Self-checking testbench for the game-pad link responder top level.
module tb_game_pad_link_responder_unit;

    import gplr_pkg::*;
    import gplr_tb_pkg::*;

    // Stimulus stops once this many exchanges have been accepted; the other
    // marks place the sender pause and the stretch without idling.
    localparam int unsigned EXCHANGES   = 800;
    localparam int unsigned PAUSE_AT    = 350;
    localparam int unsigned CALM_FROM   = 450;
    localparam int unsigned CALM_TO     = 600;
    // The receiver holds off once this many replies have been taken.
    localparam int unsigned HOLD_AT     = 300;
    localparam int unsigned HOLD_CYCLES = 80;
    // Extra wait after the last reply is in, before the verdict.
    localparam int unsigned DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;

    gplr_in_if  in_ch();
    gplr_out_if out_ch();

    game_pad_link_responder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    reply_tracker link = new();

    int unsigned beats_sent = 0;
    bit          calm       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on simulated time; reaching it reports a failure.
    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    // Pad bytes lean toward the extremes so all-pressed and all-released
    // snapshots turn up often.
    function automatic t_byte rand_byte();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return t_byte'($urandom);
    endfunction

    function automatic t_in_beat make_exchange(logic kind, t_byte host);
        t_in_beat b;
        b.kind          = kind;
        b.host_byte     = host;
        b.pad_low       = rand_byte();
        b.pad_high      = rand_byte();
        b.right_x       = rand_byte();
        b.right_y       = rand_byte();
        b.left_x        = rand_byte();
        b.left_y        = rand_byte();
        b.left_trigger  = rand_byte();
        b.right_trigger = rand_byte();
        return b;
    endfunction

    // Offers one beat and returns at the edge where it is accepted. The
    // optional idle gap before it is where valid drops, so valid never gets
    // two assignments in the same step.
    task automatic offer_exchange(t_in_beat b);
        if (!calm && $urandom_range(99) < 20) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        link.note_exchange(b);
        beats_sent++;
        calm <= (beats_sent >= CALM_FROM && beats_sent < CALM_TO);
    endtask

    task automatic send_host(t_byte host);
        offer_exchange(make_exchange(1'b0, host));
    endtask

    task automatic send_abort();
        offer_exchange(make_exchange(1'b1, t_byte'($urandom)));
    endtask

    // Command byte with a fixed pad snapshot, for the all-pressed and
    // all-released cases.
    task automatic send_with_pad(t_byte host, t_byte fill);
        t_in_beat b;
        b = make_exchange(1'b0, host);
        b.pad_low       = fill;
        b.pad_high      = fill;
        b.right_x       = fill;
        b.right_y       = fill;
        b.left_x        = fill;
        b.left_y        = fill;
        b.left_trigger  = fill;
        b.right_trigger = fill;
        offer_exchange(b);
    endtask

    // Outside config mode the host often asks to enter it, otherwise the
    // config-only commands would almost never get past the decoder.
    function automatic t_byte pick_command();
        if (!link.cfg_on && $urandom_range(99) < 45) return HOST_CONFIG;
        case ($urandom_range(13))
            0:       return HOST_POLL;
            1:       return HOST_CONFIG;
            2:       return HOST_PRES_CFG;
            3:       return HOST_POLL_CFG_STATUS;
            4:       return HOST_ANALOG_SW;
            5:       return HOST_STATUS;
            6:       return HOST_CONST46;
            7:       return HOST_CONST47;
            8:       return HOST_CONST4C;
            9:       return HOST_MOTOR;
            10:      return HOST_PRES_EN;
            11:      return HOST_ADDR;
            default: return t_byte'($urandom);
        endcase
    endfunction

    // Host byte sent while reply byte k is on the wire. The arguments that
    // change state are steered toward the values that matter.
    function automatic t_byte payload_byte(t_byte cmd_b, int unsigned k);
        int unsigned r;
        r = $urandom_range(99);
        if (cmd_b == HOST_CONFIG && k == 1) begin
            if (r < (link.cfg_on ? 50 : 25)) return 8'h00;
            if (r < 85) return 8'h01;
        end else if (cmd_b == HOST_ANALOG_SW && k == 1) begin
            if (r < 60) return ANALOG_ON;
            if (r < 80) return 8'h00;
        end else if ((cmd_b == HOST_CONST46 || cmd_b == HOST_CONST4C) && k == 1) begin
            if (r < 50) return 8'h00;
        end else if (cmd_b == HOST_PRES_EN && k >= 1 && k <= 4) begin
            if (r < 70) return 8'h00;
        end
        return rand_byte();
    endfunction

    // One random transaction: mostly an address, a command and its whole
    // reply, sometimes cut short by a select release, sometimes plain noise.
    task automatic run_transaction();
        t_byte       cmd_b;
        int unsigned k;
        if ($urandom_range(99) < 15) begin
            if ($urandom_range(9) == 0) send_abort();
            else send_host(rand_byte());
            return;
        end
        send_host(HOST_ADDR);
        if ($urandom_range(99) < 3) begin
            send_abort();
            return;
        end
        cmd_b = pick_command();
        send_host(cmd_b);
        k = 0;
        while (link.phase != PHASE_IDLE) begin
            if ($urandom_range(99) < 3) begin
                send_abort();
                return;
            end
            send_host(payload_byte(cmd_b, k));
            k++;
        end
    endtask

    // Reply side: takes a beat whenever valid and ready were both high at the
    // edge, then picks ready for the next cycle. After HOLD_AT replies it
    // holds ready low long enough for the block to back up into i_in.
    initial begin : reply_sink
        int unsigned hold  = 0;
        int unsigned taken = 0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                link.check_reply(out_ch.data);
                taken++;
                if (taken == HOLD_AT) hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else if (calm) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 20);
            end
        end
    end

    initial begin : host_side
        bit paused = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: aborts and stray bytes while idle, a config-only
        // command outside config, a digital poll with every button pressed,
        // entering config with everything released, an analog switch cut off
        // by a select release, an unknown command and a config exit.
        send_abort();
        send_host(8'h00);
        send_host(HOST_ADDR);
        send_host(HOST_MOTOR);
        send_host(HOST_ADDR);
        send_with_pad(HOST_POLL, 8'h00);
        send_host(8'hFF);
        send_host(8'hFF);
        send_host(8'hFF);
        send_host(HOST_ADDR);
        send_with_pad(HOST_CONFIG, 8'hFF);
        send_host(8'h00);
        send_host(8'h01);
        send_host(8'h00);
        send_host(HOST_ADDR);
        send_host(HOST_ANALOG_SW);
        send_host(8'h00);
        send_host(ANALOG_ON);
        send_abort();
        send_host(HOST_ADDR);
        send_host(8'hFF);
        send_host(HOST_ADDR);
        send_host(HOST_CONFIG);
        send_host(8'h00);
        send_host(8'h00);
        send_abort();

        while (beats_sent < EXCHANGES) begin
            run_transaction();
            // Once in the run the host goes quiet until every reply is in.
            if (!paused && beats_sent >= PAUSE_AT) begin
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (link.pending() != 0);
            end
        end

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (link.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (link.bad_replies == 0 && link.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
